// ===== rtl/mpfp_pkg.sv =====
package mpfp_pkg;

   typedef enum logic [2:0] {
      PH_ID_HI   = 3'd0,
      PH_ID_LO   = 3'd1,
      PH_COUNT   = 3'd2,
      PH_SIZE    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   localparam logic [2:0] KIND_ID_HI    = 3'd0;
   localparam logic [2:0] KIND_ID_LO    = 3'd1;
   localparam logic [2:0] KIND_COUNT    = 3'd2;
   localparam logic [2:0] KIND_SIZE     = 3'd3;
   localparam logic [2:0] KIND_PAYLOAD  = 3'd4;
   localparam logic [2:0] KIND_TRAILING = 3'd5;

   localparam logic [2:0] STAT_BUSY          = 3'd0;
   localparam logic [2:0] STAT_COMPLETE      = 3'd1;
   localparam logic [2:0] STAT_SHORT_HEADER  = 3'd2;
   localparam logic [2:0] STAT_SHORT_SIZE    = 3'd3;
   localparam logic [2:0] STAT_SHORT_PAYLOAD = 3'd4;

   localparam int unsigned RSP_DATA_W = 72;

   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [7:0]  byte_out;
      logic [15:0] message_id;
      logic [7:0]  param_total;
      logic [7:0]  param_index;
      logic [23:0] param_size;
      logic        param_last_byte;
      logic [2:0]  frame_status;
   } result_type;

endpackage

// ===== rtl/mpfp_core.sv =====
module mpfp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  logic               frame_end,
   output mpfp_pkg::result_type result
);
   import mpfp_pkg::*;

   phase_type   phase_ff, phase_in, phase_next;
   logic [15:0] id_ff, id_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  index_ff, index_in;
   logic [23:0] size_ff, size_in;
   logic [23:0] remaining_ff, remaining_in;
   logic [1:0]  pos_ff, pos_in;

   logic [23:0] size_shift;
   logic [23:0] remaining_dec;
   logic [7:0]  index_inc;
   phase_type   end_phase;

   assign size_shift    = {size_ff[15:0], rx_byte};
   assign remaining_dec = remaining_ff - 24'd1;
   assign index_inc     = index_ff + 8'd1;
   assign end_phase     = (index_inc >= count_ff) ? PH_DONE : PH_SIZE;

   // Phase that the current byte leaves behind, before any frame-end clear.
   always_comb begin
      phase_next = PH_DONE;
      unique case (phase_ff)
         PH_ID_HI:   phase_next = PH_ID_LO;
         PH_ID_LO:   phase_next = PH_COUNT;
         PH_COUNT:   phase_next = (rx_byte == 8'd0) ? PH_DONE : PH_SIZE;
         PH_SIZE: begin
            if (pos_ff[1]) begin
               phase_next = (size_shift == 24'd0) ? end_phase : PH_PAYLOAD;
            end else begin
               phase_next = PH_SIZE;
            end
         end
         PH_PAYLOAD: phase_next = (remaining_dec == 24'd0) ? end_phase : PH_PAYLOAD;
         PH_DONE:    phase_next = PH_DONE;
         default:    phase_next = PH_DONE;
      endcase
      phase_in = frame_end ? PH_ID_HI : phase_next;
   end

   // Field updates and the tagged result.
   always_comb begin
      id_in        = id_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      size_in      = size_ff;
      remaining_in = remaining_ff;
      pos_in       = pos_ff;

      result.byte_kind       = KIND_TRAILING;
      result.byte_out        = rx_byte;
      result.param_index     = 8'd0;
      result.param_size      = 24'd0;
      result.param_last_byte = 1'b0;

      unique case (phase_ff)
         PH_ID_HI: begin
            result.byte_kind = KIND_ID_HI;
            id_in            = {rx_byte, 8'd0};
            count_in         = 8'd0;
            index_in         = 8'd0;
            size_in          = 24'd0;
            remaining_in     = 24'd0;
            pos_in           = 2'd0;
         end
         PH_ID_LO: begin
            result.byte_kind = KIND_ID_LO;
            id_in            = {id_ff[15:8], rx_byte};
         end
         PH_COUNT: begin
            result.byte_kind = KIND_COUNT;
            count_in         = rx_byte;
            index_in         = 8'd0;
            pos_in           = 2'd0;
         end
         PH_SIZE: begin
            result.byte_kind   = KIND_SIZE;
            result.param_index = index_ff;
            size_in            = size_shift;
            if (pos_ff[1]) begin
               result.param_size = size_shift;
               remaining_in      = size_shift;
               pos_in            = 2'd0;
               if (size_shift == 24'd0) begin
                  result.param_last_byte = 1'b1;
                  index_in               = index_inc;
               end
            end else begin
               pos_in = pos_ff + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            result.byte_kind   = KIND_PAYLOAD;
            result.param_index = index_ff;
            result.param_size  = size_ff;
            remaining_in       = remaining_dec;
            if (remaining_dec == 24'd0) begin
               result.param_last_byte = 1'b1;
               index_in               = index_inc;
               pos_in                 = 2'd0;
            end
         end
         default: begin
            result.byte_kind   = KIND_TRAILING;
            result.param_index = index_ff;
         end
      endcase

      result.message_id  = id_in;
      result.param_total = count_in;

      result.frame_status = STAT_BUSY;
      if (frame_end) begin
         unique case (phase_next)
            PH_ID_LO, PH_COUNT: result.frame_status = STAT_SHORT_HEADER;
            PH_SIZE:            result.frame_status = STAT_SHORT_SIZE;
            PH_PAYLOAD:         result.frame_status = STAT_SHORT_PAYLOAD;
            default:            result.frame_status = STAT_COMPLETE;
         endcase
         id_in        = 16'd0;
         count_in     = 8'd0;
         index_in     = 8'd0;
         size_in      = 24'd0;
         remaining_in = 24'd0;
         pos_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ID_HI;
         id_ff        <= 16'd0;
         count_ff     <= 8'd0;
         index_ff     <= 8'd0;
         size_ff      <= 24'd0;
         remaining_ff <= 24'd0;
         pos_ff       <= 2'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         id_ff        <= id_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         size_ff      <= size_in;
         remaining_ff <= remaining_in;
         pos_ff       <= pos_in;
      end
   end

endmodule

// ===== rtl/mpfp_out_reg.sv =====
module mpfp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mpfp_pkg::result_type result_in,
   output logic                 load_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mpfp_pkg::result_type result_out
);
   import mpfp_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // A new result may load while the held one is taken in the same cycle.
   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign result_out = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

endmodule

// ===== rtl/message_param_frame_parser.sv =====
// A request's result is registered and appears on rsp in the cycle after it is accepted.
// Throughput: one request per cycle unless rsp_tready stalls a held result; parse state
// and result register update on acceptance, and a request is taken while a result is taken.
// Reset (synchronous, active high) returns the parser to the message id high byte
// with all fields cleared and empties the result register.
module message_param_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  logic        req_tlast,  // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_out, [23:8] message_id, [31:24] param_total, [39:32] param_index,
   // [63:40] param_size, [66:64] frame_status, [71:67] zero
   output logic [mpfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,  // [2:0] byte_kind
   output logic        rsp_tlast   // param_last_byte
);
   import mpfp_pkg::*;

   logic       req_accept;
   result_type core_result;
   result_type rsp_result;

   assign req_accept = req_tvalid && req_tready;

   mpfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .rx_byte   (req_tdata),
      .frame_end (req_tlast),
      .result    (core_result)
   );

   mpfp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .result_in  (core_result),
      .load_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .result_out (rsp_result)
   );

   assign rsp_tdata = {5'd0, rsp_result.frame_status, rsp_result.param_size,
                       rsp_result.param_index, rsp_result.param_total,
                       rsp_result.message_id, rsp_result.byte_out};
   assign rsp_tuser = rsp_result.byte_kind;
   assign rsp_tlast = rsp_result.param_last_byte;

`ifndef SYNTHESIS
   // A frame status is reported exactly for the frame's last byte.
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid &&
         ((rsp_result.frame_status != STAT_BUSY) == $past(req_tlast)))
      else $error("frame status does not follow the frame end flag");

   // The received byte is passed through unchanged.
   a_byte_pass: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_result.byte_out == $past(req_tdata))
      else $error("byte_out differs from the accepted byte");

   // Only size or payload bytes can end a parameter.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result.param_last_byte |->
         (rsp_result.byte_kind == KIND_SIZE || rsp_result.byte_kind == KIND_PAYLOAD))
      else $error("parameter end flagged on a header or trailing byte");

   // The id high byte starts a message with no count and a clear low id half.
   a_header_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result.byte_kind == KIND_ID_HI |->
         rsp_result.param_total == 8'd0 && rsp_result.message_id[7:0] == 8'd0)
      else $error("stale fields on the first header byte");
`endif

endmodule
